// ===== hw/rtl/xxh_pkg.sv =====
// shared types, primes and helper functions of the xxh64 stream hasher
package xxh_pkg;

  typedef logic [63:0] word_t;
  typedef logic [31:0] half_t;
  typedef logic [3:0]  count_t;

  localparam int unsigned NumLanes = 4;
  localparam int unsigned NumBuf   = 3;

  localparam word_t PRIME1 = 64'd11400714785074694791;
  localparam word_t PRIME2 = 64'd14029467366897019727;
  localparam word_t PRIME3 = 64'd1609587929392839161;
  localparam word_t PRIME4 = 64'd9650029242287828579;
  localparam word_t PRIME5 = 64'd2870177450012600261;

  localparam count_t FullWord = 4'd8;

  function automatic word_t rotl64(input word_t x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic word_t lane_init(input half_t seed, input logic [1:0] lane);
    word_t s;
    s = {32'd0, seed};
    case (lane)
      2'd0:    return s + PRIME1 + PRIME2;
      2'd1:    return s + PRIME2;
      2'd2:    return s;
      default: return s - PRIME1;
    endcase
  endfunction

endpackage

// ===== hw/rtl/xxh_if.sv =====
// valid/ready channel interfaces for input items, hash results and seed writes
interface xxh_in_if;
  logic             valid;
  logic             ready;
  xxh_pkg::word_t   data_word;
  xxh_pkg::count_t  byte_count;
  logic             last;

  modport source (output valid, output data_word, output byte_count, output last,
                  input ready);
  modport sink (input valid, input data_word, input byte_count, input last,
                output ready);
endinterface

interface xxh_out_if;
  logic           valid;
  logic           ready;
  xxh_pkg::word_t hash_value;

  modport source (output valid, output hash_value, input ready);
  modport sink (input valid, input hash_value, output ready);
endinterface

interface xxh_cfg_if;
  logic           valid;
  logic           ready;
  xxh_pkg::half_t seed;

  modport source (output valid, output seed, input ready);
  modport sink (input valid, input seed, output ready);
endinterface

// ===== hw/rtl/xxh_mul.sv =====
// iterative 64x64 low-half multiplier built on one 32x32 multiplier
module xxh_mul (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  xxh_pkg::word_t a_i,
  input  xxh_pkg::word_t b_i,
  output logic           done_o,
  output xxh_pkg::word_t prod_o
);

  xxh_pkg::word_t a_q, b_q, acc_q;
  xxh_pkg::half_t m_x, m_y;
  xxh_pkg::word_t m_p;
  logic [1:0]     step_q;
  logic           busy_q, done_q;

  always_comb begin
    case (step_q)
      2'd0: begin
        m_x = a_q[31:0];
        m_y = b_q[31:0];
      end
      2'd1: begin
        m_x = a_q[31:0];
        m_y = b_q[63:32];
      end
      default: begin
        m_x = a_q[63:32];
        m_y = b_q[31:0];
      end
    endcase
  end

  assign m_p = {32'd0, m_x} * {32'd0, m_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        a_q    <= a_i;
        b_q    <= b_i;
        step_q <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        step_q <= step_q + 2'd1;
        case (step_q)
          2'd0: begin
            acc_q <= m_p;
          end
          2'd1: begin
            acc_q <= acc_q + {m_p[31:0], 32'd0};
          end
          default: begin
            acc_q  <= acc_q + {m_p[31:0], 32'd0};
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        endcase
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== hw/rtl/xxhash64_stream_hasher.sv =====
// top level: xxh64 stream hasher with sequencer around a shared multiplier
//
// in_i carries one 64-bit little-endian message word per item with its byte
// count and a last flag; out_o returns one 64-bit hash per message; cfg_i
// writes the 32-bit seed and is ready only while the block waits for an item.
// Seed writes belong between messages.
// A word that does not complete a 32-byte stripe is stored without a lane
// round. The word that completes a stripe runs four lane rounds, 8 multiplies
// on the shared multiplier, and in_i stays low meanwhile. The last word adds
// the finish: setup, the lane convergence of a long message, a round per
// leftover word, one for a 4-byte chunk, one per single byte and the
// avalanche, then the load of the output register.
// The hash sits in an output register; a new message can be taken while it
// waits, and if the receiver stalls the next hash waits in the sequencer.
// Reset clears the length, the stripe count and the output, sets the seed
// to zero and seeds the lanes from it.
module xxhash64_stream_hasher (
  input logic      clk_i,
  input logic      rst_ni,
  xxh_in_if.sink   in_i,
  xxh_cfg_if.sink  cfg_i,
  xxh_out_if.source out_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RND_A,
    ST_RND_B,
    ST_FIN,
    ST_CONV,
    ST_FL_A,
    ST_FL_B,
    ST_FL_C,
    ST_ADD_LEN,
    ST_FW_A,
    ST_FW_B,
    ST_FW_C,
    ST_TAIL,
    ST_W4_A,
    ST_W4_B,
    ST_B1_A,
    ST_B1_B,
    ST_AV_A,
    ST_AV_B,
    ST_OUT
  } state_e;

  state_e          state_q;
  logic            issued_q;
  xxh_pkg::half_t  seed_q;
  xxh_pkg::word_t  lane_q [xxh_pkg::NumLanes];
  xxh_pkg::word_t  buf_q [xxh_pkg::NumBuf];
  logic [1:0]      nbuf_q;
  xxh_pkg::word_t  len_q;
  logic [1:0]      idx_q;
  xxh_pkg::word_t  h_q, t_q, data_q;
  xxh_pkg::count_t nbytes_q;
  logic [2:0]      left_q;
  logic            last_q, taken_q;
  logic            out_valid_q;
  xxh_pkg::word_t  out_hash_q;

  logic            in_fire, cfg_fire;
  xxh_pkg::count_t n_eff;
  logic            mul_state, mul_start, mul_done;
  xxh_pkg::word_t  mul_a, mul_b, mul_p;
  xxh_pkg::word_t  wsel, conv_term;

  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign n_eff    = (!in_i.last || in_i.byte_count > xxh_pkg::FullWord) ?
                    xxh_pkg::FullWord : in_i.byte_count;

  assign in_i.ready       = (state_q == ST_IDLE);
  assign cfg_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.hash_value = out_hash_q;

  always_comb begin
    case (idx_q)
      2'd0:    wsel = buf_q[0];
      2'd1:    wsel = buf_q[1];
      2'd2:    wsel = buf_q[2];
      default: wsel = data_q;
    endcase
  end

  always_comb begin
    case (idx_q)
      2'd0:    conv_term = xxh_pkg::rotl64(lane_q[0], 1);
      2'd1:    conv_term = xxh_pkg::rotl64(lane_q[1], 7);
      2'd2:    conv_term = xxh_pkg::rotl64(lane_q[2], 12);
      default: conv_term = xxh_pkg::rotl64(lane_q[3], 18);
    endcase
  end

  always_comb begin
    mul_state = 1'b1;
    case (state_q)
      ST_RND_A: begin
        mul_a = wsel;
        mul_b = xxh_pkg::PRIME2;
      end
      ST_RND_B, ST_FL_B, ST_FW_B: begin
        mul_a = t_q;
        mul_b = xxh_pkg::PRIME1;
      end
      ST_FL_A: begin
        mul_a = lane_q[idx_q];
        mul_b = xxh_pkg::PRIME2;
      end
      ST_FL_C: begin
        mul_a = h_q;
        mul_b = xxh_pkg::PRIME1;
      end
      ST_FW_A: begin
        mul_a = wsel;
        mul_b = xxh_pkg::PRIME2;
      end
      ST_FW_C: begin
        mul_a = xxh_pkg::rotl64(h_q, 27);
        mul_b = xxh_pkg::PRIME1;
      end
      ST_W4_A: begin
        mul_a = {32'd0, data_q[31:0]};
        mul_b = xxh_pkg::PRIME1;
      end
      ST_W4_B: begin
        mul_a = xxh_pkg::rotl64(h_q, 23);
        mul_b = xxh_pkg::PRIME2;
      end
      ST_B1_A: begin
        mul_a = {56'd0, data_q[7:0]};
        mul_b = xxh_pkg::PRIME5;
      end
      ST_B1_B: begin
        mul_a = xxh_pkg::rotl64(h_q, 11);
        mul_b = xxh_pkg::PRIME1;
      end
      ST_AV_A: begin
        mul_a = h_q ^ (h_q >> 33);
        mul_b = xxh_pkg::PRIME2;
      end
      ST_AV_B: begin
        mul_a = h_q ^ (h_q >> 29);
        mul_b = xxh_pkg::PRIME3;
      end
      default: begin
        mul_state = 1'b0;
        mul_a     = h_q;
        mul_b     = xxh_pkg::PRIME1;
      end
    endcase
  end

  assign mul_start = mul_state && !issued_q;

  xxh_mul u_xxh_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  // stripe words awaiting the fourth
  always_ff @(posedge clk_i) begin
    if (in_fire && !in_i.last && nbuf_q != 2'd3) begin
      buf_q[nbuf_q] <= in_i.data_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      seed_q      <= '0;
      for (int i = 0; i < xxh_pkg::NumLanes; i++) begin
        lane_q[i] <= xxh_pkg::lane_init('0, 2'(i));
      end
      nbuf_q      <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      h_q         <= '0;
      t_q         <= '0;
      data_q      <= '0;
      nbytes_q    <= '0;
      left_q      <= '0;
      last_q      <= 1'b0;
      taken_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_hash_q  <= '0;
    end else begin
      if (out_o.valid && out_o.ready && state_q != ST_OUT) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_fire) begin
        seed_q <= cfg_i.seed;
        if (len_q == '0 && nbuf_q == '0) begin
          for (int i = 0; i < xxh_pkg::NumLanes; i++) begin
            lane_q[i] <= xxh_pkg::lane_init(cfg_i.seed, 2'(i));
          end
        end
      end
      if (mul_start) begin
        issued_q <= 1'b1;
      end
      if (mul_done) begin
        issued_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            len_q    <= len_q + {60'd0, n_eff};
            data_q   <= in_i.data_word;
            last_q   <= in_i.last;
            nbytes_q <= n_eff;
            if (n_eff == xxh_pkg::FullWord && nbuf_q == 2'd3) begin
              taken_q <= 1'b1;
              nbuf_q  <= '0;
              idx_q   <= '0;
              state_q <= ST_RND_A;
            end else if (!in_i.last) begin
              nbuf_q <= nbuf_q + 2'd1;
            end else begin
              taken_q <= 1'b0;
              state_q <= ST_FIN;
            end
          end
        end
        ST_RND_A: begin
          if (mul_done) begin
            t_q     <= xxh_pkg::rotl64(lane_q[idx_q] + mul_p, 31);
            state_q <= ST_RND_B;
          end
        end
        ST_RND_B: begin
          if (mul_done) begin
            lane_q[idx_q] <= mul_p;
            if (idx_q == 2'd3) begin
              idx_q   <= '0;
              state_q <= last_q ? ST_FIN : ST_IDLE;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_RND_A;
            end
          end
        end
        ST_FIN: begin
          idx_q <= '0;
          if (len_q >= 64'd32) begin
            h_q     <= '0;
            state_q <= ST_CONV;
          end else begin
            h_q     <= {32'd0, seed_q} + xxh_pkg::PRIME5;
            state_q <= ST_ADD_LEN;
          end
        end
        ST_CONV: begin
          h_q <= h_q + conv_term;
          if (idx_q == 2'd3) begin
            idx_q   <= '0;
            state_q <= ST_FL_A;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        ST_FL_A: begin
          if (mul_done) begin
            t_q     <= xxh_pkg::rotl64(mul_p, 31);
            state_q <= ST_FL_B;
          end
        end
        ST_FL_B: begin
          if (mul_done) begin
            h_q     <= h_q ^ mul_p;
            state_q <= ST_FL_C;
          end
        end
        ST_FL_C: begin
          if (mul_done) begin
            h_q <= mul_p + xxh_pkg::PRIME4;
            if (idx_q == 2'd3) begin
              idx_q   <= '0;
              state_q <= ST_ADD_LEN;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_FL_A;
            end
          end
        end
        ST_ADD_LEN: begin
          h_q     <= h_q + len_q;
          idx_q   <= '0;
          state_q <= (nbuf_q != '0) ? ST_FW_A : ST_TAIL;
        end
        ST_FW_A: begin
          if (mul_done) begin
            t_q     <= xxh_pkg::rotl64(mul_p, 31);
            state_q <= ST_FW_B;
          end
        end
        ST_FW_B: begin
          if (mul_done) begin
            h_q     <= h_q ^ mul_p;
            state_q <= ST_FW_C;
          end
        end
        ST_FW_C: begin
          if (mul_done) begin
            h_q <= mul_p + xxh_pkg::PRIME4;
            if (idx_q == 2'd3) begin
              state_q <= ST_AV_A;
            end else if (idx_q == nbuf_q - 2'd1) begin
              state_q <= ST_TAIL;
            end else begin
              idx_q   <= idx_q + 2'd1;
              state_q <= ST_FW_A;
            end
          end
        end
        ST_TAIL: begin
          if (taken_q) begin
            state_q <= ST_AV_A;
          end else if (nbytes_q == xxh_pkg::FullWord) begin
            idx_q   <= 2'd3;
            state_q <= ST_FW_A;
          end else if (nbytes_q >= 4'd4) begin
            left_q  <= nbytes_q[2:0] - 3'd4;
            state_q <= ST_W4_A;
          end else if (nbytes_q != '0) begin
            left_q  <= nbytes_q[2:0];
            state_q <= ST_B1_A;
          end else begin
            state_q <= ST_AV_A;
          end
        end
        ST_W4_A: begin
          if (mul_done) begin
            h_q     <= h_q ^ mul_p;
            state_q <= ST_W4_B;
          end
        end
        ST_W4_B: begin
          if (mul_done) begin
            h_q     <= mul_p + xxh_pkg::PRIME3;
            data_q  <= data_q >> 32;
            state_q <= (left_q == '0) ? ST_AV_A : ST_B1_A;
          end
        end
        ST_B1_A: begin
          if (mul_done) begin
            h_q     <= h_q ^ mul_p;
            state_q <= ST_B1_B;
          end
        end
        ST_B1_B: begin
          if (mul_done) begin
            h_q     <= mul_p;
            data_q  <= data_q >> 8;
            left_q  <= left_q - 3'd1;
            state_q <= (left_q == 3'd1) ? ST_AV_A : ST_B1_A;
          end
        end
        ST_AV_A: begin
          if (mul_done) begin
            h_q     <= mul_p;
            state_q <= ST_AV_B;
          end
        end
        ST_AV_B: begin
          if (mul_done) begin
            h_q     <= mul_p ^ (mul_p >> 32);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            out_hash_q  <= h_q;
            for (int i = 0; i < xxh_pkg::NumLanes; i++) begin
              lane_q[i] <= xxh_pkg::lane_init(seed_q, 2'(i));
            end
            nbuf_q  <= '0;
            len_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/xxh_checker.sv =====
// port-level assertions for the xxh64 stream hasher and their bind
module xxh_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           in_last_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input xxh_pkg::word_t out_hash_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("hash item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_hash_i))
    else $error("hash changed while stalled");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("input ready right after last item");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i))
    else $error("hash appeared without a finish sequence");

endmodule

bind xxhash64_stream_hasher xxh_checker u_xxh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_last_i   (in_i.last),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hash_i  (out_o.hash_value)
);

// ===== tb/xxh64_digest_checker.sv =====
// checker for the xxh64 stream hasher: predicts each message hash and compares results
`timescale 1ns / 1ps

module xxh64_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  xxh_in_if           in_ch,
  xxh_cfg_if          cfg_ch,
  xxh_out_if          out_ch,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam xxh_pkg::word_t K1 = 64'd11400714785074694791;
  localparam xxh_pkg::word_t K2 = 64'd14029467366897019727;
  localparam xxh_pkg::word_t K3 = 64'd1609587929392839161;
  localparam xxh_pkg::word_t K4 = 64'd9650029242287828579;
  localparam xxh_pkg::word_t K5 = 64'd2870177450012600261;

  xxh_pkg::half_t seed_q;
  xxh_pkg::word_t lanes [4];
  xxh_pkg::word_t held [3];
  int unsigned    held_cnt;
  xxh_pkg::word_t msg_len;
  xxh_pkg::word_t digest_q [$];

  function automatic xxh_pkg::word_t rot_left(input xxh_pkg::word_t x, input int unsigned r);
    logic [127:0] dbl;
    dbl = {x, x};
    return dbl[127 - r -: 64];
  endfunction

  function automatic xxh_pkg::word_t mix_round(input xxh_pkg::word_t acc,
                                               input xxh_pkg::word_t w);
    acc = acc + w * K2;
    return rot_left(acc, 31) * K1;
  endfunction

  task automatic load_lanes();
    xxh_pkg::word_t s;
    s = {32'd0, seed_q};
    lanes[0] = s + K1 + K2;
    lanes[1] = s + K2;
    lanes[2] = s;
    lanes[3] = s - K1;
  endtask

  task automatic take_seed(input xxh_pkg::half_t s);
    seed_q = s;
    if (msg_len == 0 && held_cnt == 0) begin
      load_lanes();
    end
  endtask

  task automatic report_mismatch(input string what, input xxh_pkg::word_t got,
                                 input xxh_pkg::word_t want);
    $display("%0t mismatch: %s got %h want %h", $time, what, got, want);
    fail_count_o = fail_count_o + 1;
  endtask

  task automatic absorb_word(input xxh_pkg::word_t data, input xxh_pkg::count_t cnt,
                             input logic lst);
    int unsigned    nb;
    int unsigned    left;
    bit             stored;
    xxh_pkg::word_t h;
    xxh_pkg::word_t rest;
    nb = (!lst || cnt > xxh_pkg::FullWord) ? 8 : int'(cnt);
    msg_len = msg_len + nb;
    stored = 1'b0;
    if (nb == 8 && held_cnt >= 3) begin
      for (int i = 0; i < 3; i++) begin
        lanes[i] = mix_round(lanes[i], held[i]);
      end
      lanes[3] = mix_round(lanes[3], data);
      held_cnt = 0;
      stored = 1'b1;
    end else if (!lst) begin
      held[held_cnt] = data;
      held_cnt = held_cnt + 1;
      stored = 1'b1;
    end
    if (!lst) begin
      return;
    end
    if (msg_len >= 32) begin
      h = rot_left(lanes[0], 1) + rot_left(lanes[1], 7) + rot_left(lanes[2], 12) +
          rot_left(lanes[3], 18);
      for (int i = 0; i < 4; i++) begin
        h = (h ^ mix_round('0, lanes[i])) * K1 + K4;
      end
    end else begin
      h = {32'd0, seed_q} + K5;
    end
    h = h + msg_len;
    for (int i = 0; i < held_cnt; i++) begin
      h = rot_left(h ^ mix_round('0, held[i]), 27) * K1 + K4;
    end
    if (!stored) begin
      if (nb == 8) begin
        h = rot_left(h ^ mix_round('0, data), 27) * K1 + K4;
      end else begin
        rest = data;
        left = nb;
        if (left >= 4) begin
          h = h ^ ((rest & 64'hFFFF_FFFF) * K1);
          h = rot_left(h, 23) * K2 + K3;
          rest = rest >> 32;
          left = left - 4;
        end
        while (left > 0) begin
          h = h ^ ((rest & 64'hFF) * K5);
          h = rot_left(h, 11) * K1;
          rest = rest >> 8;
          left = left - 1;
        end
      end
    end
    h = h ^ (h >> 33);
    h = h * K2;
    h = h ^ (h >> 29);
    h = h * K3;
    h = h ^ (h >> 32);
    digest_q.push_back(h);
    held_cnt = 0;
    msg_len = '0;
    load_lanes();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      seed_q = '0;
      held_cnt = 0;
      msg_len = '0;
      fail_count_o = 0;
      load_lanes();
      digest_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected hash_value", out_ch.hash_value, '0);
        end else if (out_ch.hash_value !== digest_q[0]) begin
          report_mismatch("hash_value", out_ch.hash_value, digest_q.pop_front());
        end else begin
          void'(digest_q.pop_front());
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        take_seed(cfg_ch.seed);
      end
      if (in_ch.valid && in_ch.ready) begin
        absorb_word(in_ch.data_word, in_ch.byte_count, in_ch.last);
      end
    end
    pending_o = digest_q.size();
  end

endmodule

// ===== tb/tb_xxhash64_stream_hasher.sv =====
// testbench top for the xxh64 stream hasher: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_xxhash64_stream_hasher;

  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned SettleCycles = 300;
  localparam int unsigned HoldCycles   = 1000;
  localparam int unsigned MaxCycles    = 2000000;
  localparam int unsigned PhaseItems   = 250;
  localparam int unsigned NumPhases    = 6;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned sent_items = 0;
  int unsigned in_idle_pct = 0;
  int unsigned out_idle_pct = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;

  xxh_in_if  in_ch ();
  xxh_cfg_if cfg_ch ();
  xxh_out_if out_ch ();

  xxhash64_stream_hasher DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  xxh64_digest_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_ch        (in_ch),
    .cfg_ch       (cfg_ch),
    .out_ch       (out_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= MaxCycles) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result receiver with random stall bursts and one long hold-off
  initial begin : receiver
    int unsigned gap;
    bit          hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < out_idle_pct) begin
        gap = $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  function automatic xxh_pkg::word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic xxh_pkg::count_t body_count();
    if ($urandom_range(0, 9) == 0) begin
      return xxh_pkg::count_t'($urandom_range(0, 15));
    end
    return xxh_pkg::FullWord;
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return $urandom_range(0, 31);
    end else if (r < 80) begin
      return $urandom_range(32, 100);
    end else if (r < 95) begin
      return $urandom_range(101, 250);
    end
    return $urandom_range(251, 600);
  endfunction

  // called just after a falling edge, returns just after a falling edge
  task automatic send_word(input xxh_pkg::word_t data, input xxh_pkg::count_t cnt,
                           input logic lst);
    int unsigned gap;
    if (!no_idle && $urandom_range(0, 99) < in_idle_pct) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_word  <= data;
    in_ch.byte_count <= cnt;
    in_ch.last       <= lst;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sent_items = sent_items + 1;
    @(negedge clk_i);
  endtask

  task automatic send_message(input int unsigned nbytes);
    int unsigned full;
    int unsigned rem;
    full = nbytes / 8;
    rem  = nbytes % 8;
    if (rem != 0) begin
      repeat (full) send_word(rand_word(), body_count(), 1'b0);
      send_word(rand_word(), xxh_pkg::count_t'(rem), 1'b1);
    end else if (full == 0 || $urandom_range(0, 3) == 0) begin
      repeat (full) send_word(rand_word(), body_count(), 1'b0);
      send_word(rand_word(), '0, 1'b1);
    end else begin
      repeat (full - 1) send_word(rand_word(), body_count(), 1'b0);
      send_word(rand_word(),
                ($urandom_range(0, 3) == 0) ? xxh_pkg::count_t'($urandom_range(9, 15)) :
                                              xxh_pkg::FullWord,
                1'b1);
    end
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_seed(input xxh_pkg::half_t s);
    wait_quiet();
    cfg_ch.valid <= 1'b1;
    cfg_ch.seed  <= s;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    xxh_pkg::half_t phase_seed;
    int unsigned    target;
    int unsigned    msg_cnt;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.data_word  = '0;
    in_ch.byte_count = '0;
    in_ch.last       = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.seed      = '0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: edge byte counts, exact stripe, empty tails, seed writes mid-message
    send_word('1, '0, 1'b1);
    send_word('1, 4'd15, 1'b1);
    send_word({$urandom, $urandom}, 4'd3, 1'b1);
    send_word('1, 4'd4, 1'b1);
    send_word({$urandom, $urandom}, 4'd9, 1'b1);
    send_word('0, xxh_pkg::FullWord, 1'b0);
    send_word('1, xxh_pkg::FullWord, 1'b0);
    send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b0);
    send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b1);
    send_word({$urandom, $urandom}, 4'd0, 1'b0);
    send_word({$urandom, $urandom}, 4'd15, 1'b0);
    send_word('1, 4'd7, 1'b1);
    repeat (5) send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b0);
    send_word('1, '0, 1'b1);
    send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b0);
    write_seed(32'hDEAD_BEEF);
    send_word({$urandom, $urandom}, 4'd6, 1'b1);
    repeat (3) send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b0);
    write_seed(32'h0000_0001);
    send_word({$urandom, $urandom}, xxh_pkg::FullWord, 1'b1);

    // random phases, each under its own seed
    msg_cnt = 0;
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0:       phase_seed = 32'hFFFF_FFFF;
        1:       phase_seed = 32'h0000_0000;
        3:       phase_seed = 32'h8000_0000;
        default: phase_seed = $urandom;
      endcase
      write_seed(phase_seed);
      if (ph == NumPhases - 1) begin
        no_idle = 1'b1;
      end
      if (ph == 1) begin
        hold_req = 1'b1;
        repeat (12) send_message($urandom_range(0, 31));
      end
      target = sent_items + PhaseItems;
      while (sent_items < target) begin
        if (msg_cnt % 16 == 0) begin
          in_idle_pct  = $urandom_range(0, 3) * 15;
          out_idle_pct = $urandom_range(0, 3) * 3;
        end
        send_message(pick_length());
        msg_cnt = msg_cnt + 1;
      end
    end

    wait_quiet();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
